/* rtl/ssw_pkg.sv */
// ----------------------------------------------------------------------------
// ssw_pkg: shared types, constants and the sine table function
// Register map, default widths and the (sin+1)/2 table entry generator used by
// the summed sine wave pixel color pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package ssw_pkg;

  localparam int WAVE_COUNT     = 3;
  localparam int NUM_CHANNELS   = 3;
  localparam int NUM_STAGES     = 5;
  localparam int CHAN_BITS      = 8;
  localparam int STEP_BITS      = 16;
  localparam int COLOR_BITS     = 24;
  localparam int MOTION_BITS    = 33;
  localparam int CFG_DATA_BITS  = 33;
  localparam int CFG_INDEX_BITS = 3;
  localparam int MOTION_EN_BIT  = 32;

  localparam int DEF_PHASE_BITS     = 16;
  localparam int DEF_SINE_ADDR_BITS = 10;
  localparam int DEF_INTENSITY_BITS = 10;

  localparam logic [63:0] TWOPI_Q30 = 64'd6746518852;
  localparam logic [63:0] ONE_Q30   = 64'd1 << 30;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_WAVE0_COLOR  = 3'd0,
    CFG_WAVE1_COLOR  = 3'd1,
    CFG_WAVE2_COLOR  = 3'd2,
    CFG_WAVE0_MOTION = 3'd3,
    CFG_WAVE1_MOTION = 3'd4,
    CFG_WAVE2_MOTION = 3'd5
  } cfg_reg_t;

  // Table entry for quarter-wave index q: round((1 +/- sin) / 2) as an
  // int_bits-bit fraction, sine taken from a truncated Q30 Taylor series.
  function automatic logic [15:0] sine_entry(int addr_bits, int int_bits, int q,
                                             logic neg);
    logic [63:0] theta;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] max_val;
    theta = (64'(q) * TWOPI_Q30) >> addr_bits;
    term  = theta;
    sum   = theta;
    for (int k = 1; k <= 5; k++) begin
      term = (term * theta) >> 30;
      term = (term * theta) >> 30;
      term = term / 64'((2 * k) * (2 * k + 1));
      if (k[0]) begin
        sum = (sum > term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    if (sum > ONE_Q30) begin
      sum = ONE_Q30;
    end
    v       = neg ? (ONE_Q30 - sum) : (ONE_Q30 + sum);
    res     = ((v << int_bits) + ONE_Q30) >> 31;
    max_val = (64'd1 << int_bits) - 64'd1;
    if (res > max_val) begin
      res = max_val;
    end
    return res[15:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/ssw_phase.sv */
// ----------------------------------------------------------------------------
// ssw_phase: wave phase and table index (pipeline stages 1 and 2)
// Stage 1 forms the spatial and temporal step products, stage 2 adds them,
// aligns the phase and folds the table address onto a quarter wave.
// ----------------------------------------------------------------------------
`default_nettype none

module ssw_phase
  import ssw_pkg::*;
#(
  parameter int PHASE_BITS     = DEF_PHASE_BITS,
  parameter int SINE_ADDR_BITS = DEF_SINE_ADDR_BITS
) (
  input  wire logic                         clk,
  input  wire logic                         s1_en,
  input  wire logic                         s2_en,
  input  wire logic [STEP_BITS-1:0]         pixel_index,
  input  wire logic [STEP_BITS-1:0]         frame_number,
  input  wire logic [MOTION_BITS-1:0]       motion   [WAVE_COUNT],
  output logic      [SINE_ADDR_BITS-2:0]    quarter_idx [WAVE_COUNT],
  output logic                              lower_half  [WAVE_COUNT],
  output logic                              wave_on     [WAVE_COUNT]
);

  localparam int QUARTER = 1 << (SINE_ADDR_BITS - 2);

  logic [STEP_BITS-1:0]      sprod_r [WAVE_COUNT];
  logic [STEP_BITS-1:0]      tprod_r [WAVE_COUNT];
  logic                      on1_r   [WAVE_COUNT];
  logic [SINE_ADDR_BITS-2:0] q_r     [WAVE_COUNT];
  logic                      neg_r   [WAVE_COUNT];
  logic                      on2_r   [WAVE_COUNT];

  logic [SINE_ADDR_BITS-2:0] q_nxt   [WAVE_COUNT];
  logic                      neg_nxt [WAVE_COUNT];

  // stage 1: step products, only the turn fraction is kept
  always_ff @(posedge clk) begin
    if (s1_en) begin
      for (int w = 0; w < WAVE_COUNT; w++) begin
        sprod_r[w] <= STEP_BITS'(pixel_index * motion[w][31:16]);
        tprod_r[w] <= STEP_BITS'(frame_number * motion[w][15:0]);
        on1_r[w]   <= motion[w][MOTION_EN_BIT];
      end
    end
  end

  always_comb begin
    for (int w = 0; w < WAVE_COUNT; w++) begin
      logic [STEP_BITS-1:0]         raw;
      logic [STEP_BITS+23:0]        raw_ext;
      logic [PHASE_BITS-1:0]        phase;
      logic [PHASE_BITS+11:0]       phase_ext;
      logic [SINE_ADDR_BITS-1:0]    addr;
      logic [SINE_ADDR_BITS-3:0]    low;
      raw       = STEP_BITS'(sprod_r[w] + tprod_r[w]);
      // align to the phase width, then take the top address bits
      raw_ext   = {raw, 24'd0};
      phase     = raw_ext[STEP_BITS+23 -: PHASE_BITS];
      phase_ext = {phase, 12'd0};
      addr      = phase_ext[PHASE_BITS+11 -: SINE_ADDR_BITS];
      low       = addr[SINE_ADDR_BITS-3:0];
      // mirror odd quadrants onto the rising quarter
      q_nxt[w]   = addr[SINE_ADDR_BITS-2] ?
                   ((SINE_ADDR_BITS-1)'(QUARTER) - {1'b0, low}) : {1'b0, low};
      neg_nxt[w] = addr[SINE_ADDR_BITS-1];
    end
  end

  // stage 2
  always_ff @(posedge clk) begin
    if (s2_en) begin
      for (int w = 0; w < WAVE_COUNT; w++) begin
        q_r[w]   <= q_nxt[w];
        neg_r[w] <= neg_nxt[w];
        on2_r[w] <= on1_r[w];
      end
    end
  end

  always_comb begin
    for (int w = 0; w < WAVE_COUNT; w++) begin
      quarter_idx[w] = q_r[w];
      lower_half[w]  = neg_r[w];
      wave_on[w]     = on2_r[w];
    end
  end

endmodule

`default_nettype wire

/* rtl/ssw_lookup.sv */
// ----------------------------------------------------------------------------
// ssw_lookup: sine table read (pipeline stage 3)
// Quarter-wave tables for the upper and lower half wave, one read per wave,
// registered. A disabled wave reads as zero intensity.
// ----------------------------------------------------------------------------
`default_nettype none

module ssw_lookup
  import ssw_pkg::*;
#(
  parameter int SINE_ADDR_BITS = DEF_SINE_ADDR_BITS,
  parameter int INTENSITY_BITS = DEF_INTENSITY_BITS
) (
  input  wire logic                         clk,
  input  wire logic                         s3_en,
  input  wire logic [SINE_ADDR_BITS-2:0]    quarter_idx [WAVE_COUNT],
  input  wire logic                         lower_half  [WAVE_COUNT],
  input  wire logic                         wave_on     [WAVE_COUNT],
  output logic      [INTENSITY_BITS-1:0]    intensity   [WAVE_COUNT]
);

  localparam int QUARTER = 1 << (SINE_ADDR_BITS - 2);

  logic [INTENSITY_BITS-1:0] rom_upper [QUARTER+1];
  logic [INTENSITY_BITS-1:0] rom_lower [QUARTER+1];
  logic [INTENSITY_BITS-1:0] inten_r   [WAVE_COUNT];
  logic [INTENSITY_BITS-1:0] inten_nxt [WAVE_COUNT];

  // constant contents, folded at elaboration
  always_comb begin
    for (int i = 0; i <= QUARTER; i++) begin
      rom_upper[i] = INTENSITY_BITS'(sine_entry(SINE_ADDR_BITS, INTENSITY_BITS, i, 1'b0));
      rom_lower[i] = INTENSITY_BITS'(sine_entry(SINE_ADDR_BITS, INTENSITY_BITS, i, 1'b1));
    end
  end

  always_comb begin
    for (int w = 0; w < WAVE_COUNT; w++) begin
      if (!wave_on[w]) begin
        inten_nxt[w] = '0;
      end else if (lower_half[w]) begin
        inten_nxt[w] = rom_lower[quarter_idx[w]];
      end else begin
        inten_nxt[w] = rom_upper[quarter_idx[w]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s3_en) begin
      for (int w = 0; w < WAVE_COUNT; w++) begin
        inten_r[w] <= inten_nxt[w];
      end
    end
  end

  always_comb begin
    for (int w = 0; w < WAVE_COUNT; w++) begin
      intensity[w] = inten_r[w];
    end
  end

endmodule

`default_nettype wire

/* rtl/ssw_mix.sv */
// ----------------------------------------------------------------------------
// ssw_mix: color scaling and channel sums (pipeline stages 4 and 5)
// Stage 4 scales each wave's channels by its intensity, stage 5 adds the
// waves per channel, drops the fraction and saturates; it is the output
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module ssw_mix
  import ssw_pkg::*;
#(
  parameter int INTENSITY_BITS = DEF_INTENSITY_BITS
) (
  input  wire logic                         clk,
  input  wire logic                         s4_en,
  input  wire logic                         s5_en,
  input  wire logic [INTENSITY_BITS-1:0]    intensity [WAVE_COUNT],
  input  wire logic [COLOR_BITS-1:0]        color     [WAVE_COUNT],
  output logic      [CHAN_BITS-1:0]         red,
  output logic      [CHAN_BITS-1:0]         green,
  output logic      [CHAN_BITS-1:0]         blue
);

  localparam int PROD_BITS = INTENSITY_BITS + CHAN_BITS;
  localparam int SUM_BITS  = PROD_BITS + 2;

  logic [PROD_BITS-1:0] prod_r   [WAVE_COUNT][NUM_CHANNELS];
  logic [CHAN_BITS-1:0] chan_r   [NUM_CHANNELS];
  logic [CHAN_BITS-1:0] chan_nxt [NUM_CHANNELS];

  // stage 4: channel 0 is red (bits 23:16)
  always_ff @(posedge clk) begin
    if (s4_en) begin
      for (int w = 0; w < WAVE_COUNT; w++) begin
        for (int c = 0; c < NUM_CHANNELS; c++) begin
          prod_r[w][c] <= PROD_BITS'(intensity[w])
                          * PROD_BITS'(color[w][COLOR_BITS-1-CHAN_BITS*c -: CHAN_BITS]);
        end
      end
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      logic [SUM_BITS-1:0] sum;
      logic [9:0]          whole;
      sum = SUM_BITS'(prod_r[0][c]) + SUM_BITS'(prod_r[1][c]) + SUM_BITS'(prod_r[2][c]);
      whole = sum[SUM_BITS-1:INTENSITY_BITS];
      chan_nxt[c] = (whole > 10'd255) ? 8'hFF : whole[CHAN_BITS-1:0];
    end
  end

  // stage 5
  always_ff @(posedge clk) begin
    if (s5_en) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        chan_r[c] <= chan_nxt[c];
      end
    end
  end

  assign red   = chan_r[0];
  assign green = chan_r[1];
  assign blue  = chan_r[2];

endmodule

`default_nettype wire

/* rtl/summed_sine_wave_pixel_color.sv */
// ----------------------------------------------------------------------------
// summed_sine_wave_pixel_color: three-wave sine color generator for one strip
// Each pixel request returns one RGB color, the saturated sum of up to three
// enabled waves whose color is scaled by a (sin+1)/2 table value.
// ----------------------------------------------------------------------------
// Takes one pixel request per clock while in_tready is high, in stages:
// step products, phase and quarter-wave fold, table read, channel scaling,
// then channel sum with saturation into the output register. Each stage
// holds independently on backpressure, so empty stages keep filling while a
// result waits. Write the wave registers only while no request is in flight.
`default_nettype none

module summed_sine_wave_pixel_color
  import ssw_pkg::*;
#(
  parameter int PHASE_BITS     = DEF_PHASE_BITS,
  parameter int SINE_ADDR_BITS = DEF_SINE_ADDR_BITS,
  parameter int INTENSITY_BITS = DEF_INTENSITY_BITS
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  input  wire logic [31:0]               in_tdata,   // frame_number, pixel_index
  input  wire logic                      in_tlast,   // last_pixel
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic      [23:0]               out_tdata,  // blue, green, red
  output logic                           out_tlast,  // frame_end
  input  wire logic                      cfg_we,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_wdata
);

  logic [COLOR_BITS-1:0]     color_r  [WAVE_COUNT];
  logic [MOTION_BITS-1:0]    motion_r [WAVE_COUNT];
  logic [NUM_STAGES-1:0]     valid_r;
  logic [NUM_STAGES-1:0]     last_r;
  logic [NUM_STAGES-1:0]     stage_en;

  logic [SINE_ADDR_BITS-2:0] quarter_idx [WAVE_COUNT];
  logic                      lower_half  [WAVE_COUNT];
  logic                      wave_on     [WAVE_COUNT];
  logic [INTENSITY_BITS-1:0] intensity   [WAVE_COUNT];
  logic [CHAN_BITS-1:0]      red;
  logic [CHAN_BITS-1:0]      green;
  logic [CHAN_BITS-1:0]      blue;

  // configuration writes; out-of-range indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < WAVE_COUNT; w++) begin
        color_r[w]  <= '0;
        motion_r[w] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_WAVE0_COLOR:  color_r[0]  <= cfg_wdata[COLOR_BITS-1:0];
        CFG_WAVE1_COLOR:  color_r[1]  <= cfg_wdata[COLOR_BITS-1:0];
        CFG_WAVE2_COLOR:  color_r[2]  <= cfg_wdata[COLOR_BITS-1:0];
        CFG_WAVE0_MOTION: motion_r[0] <= cfg_wdata[MOTION_BITS-1:0];
        CFG_WAVE1_MOTION: motion_r[1] <= cfg_wdata[MOTION_BITS-1:0];
        CFG_WAVE2_MOTION: motion_r[2] <= cfg_wdata[MOTION_BITS-1:0];
        default: ;
      endcase
    end
  end

  // a stage advances when empty or when the stage after it advances
  always_comb begin
    stage_en[NUM_STAGES-1] = !valid_r[NUM_STAGES-1] || out_tready;
    for (int s = NUM_STAGES - 2; s >= 0; s--) begin
      stage_en[s] = !valid_r[s] || stage_en[s+1];
    end
  end

  assign in_tready = stage_en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (stage_en[0]) begin
        valid_r[0] <= in_tvalid;
      end
      for (int s = 1; s < NUM_STAGES; s++) begin
        if (stage_en[s]) begin
          valid_r[s] <= valid_r[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      last_r[0] <= in_tlast;
    end
    for (int s = 1; s < NUM_STAGES; s++) begin
      if (stage_en[s]) begin
        last_r[s] <= last_r[s-1];
      end
    end
  end

  ssw_phase #(
    .PHASE_BITS     (PHASE_BITS),
    .SINE_ADDR_BITS (SINE_ADDR_BITS)
  ) u_phase (
    .clk          (clk),
    .s1_en        (stage_en[0]),
    .s2_en        (stage_en[1]),
    .pixel_index  (in_tdata[15:0]),
    .frame_number (in_tdata[31:16]),
    .motion       (motion_r),
    .quarter_idx  (quarter_idx),
    .lower_half   (lower_half),
    .wave_on      (wave_on)
  );

  ssw_lookup #(
    .SINE_ADDR_BITS (SINE_ADDR_BITS),
    .INTENSITY_BITS (INTENSITY_BITS)
  ) u_lookup (
    .clk         (clk),
    .s3_en       (stage_en[2]),
    .quarter_idx (quarter_idx),
    .lower_half  (lower_half),
    .wave_on     (wave_on),
    .intensity   (intensity)
  );

  ssw_mix #(
    .INTENSITY_BITS (INTENSITY_BITS)
  ) u_mix (
    .clk       (clk),
    .s4_en     (stage_en[3]),
    .s5_en     (stage_en[4]),
    .intensity (intensity),
    .color     (color_r),
    .red       (red),
    .green     (green),
    .blue      (blue)
  );

  assign out_tvalid = valid_r[NUM_STAGES-1];
  assign out_tdata  = {blue, green, red};
  assign out_tlast  = last_r[NUM_STAGES-1];

`ifndef SYNTH
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> valid_r[0])
    else $error("accepted request did not enter stage 1");

  a_full_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (&valid_r) && !out_tready |-> !in_tready)
    else $error("request taken while the pipeline is full and stalled");

  a_out_follows_s4: assert property (@(posedge clk) disable iff (!rst_n)
    stage_en[NUM_STAGES-1] |=> valid_r[NUM_STAGES-1] == $past(valid_r[NUM_STAGES-2]))
    else $error("output stage did not take stage 4");

  a_stalled_out_holds_tag: assert property (@(posedge clk) disable iff (!rst_n)
    !stage_en[NUM_STAGES-1] |=> $stable(last_r[NUM_STAGES-1]) && valid_r[NUM_STAGES-1])
    else $error("held result lost its frame marker");
`endif

endmodule

`default_nettype wire
